@@ design/imb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// imb_pkg
// shared constants and word types of the interference matrix builder
// ----------------------------------------------------------------------------
package imb_pkg;

  // number of temporaries tracked, one matrix row and one column each
  localparam int NUM_TEMPS = 64;
  localparam int TEMP_W    = (NUM_TEMPS > 1) ? $clog2(NUM_TEMPS) : 1;

  localparam int MASK_W    = 64;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 64;

  // request codes
  localparam logic [1:0] REQ_BLOCK_START = 2'd0;
  localparam logic [1:0] REQ_OPERATION   = 2'd1;
  localparam logic [1:0] REQ_ADD_EDGE    = 2'd2;
  localparam logic [1:0] REQ_QUERY_EDGE  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEMBER_MASK   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COALESCE_EN   = 1'd1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [MASK_W-1:0] live_init_mask;
    logic [MASK_W-1:0] def_mask;
    logic [MASK_W-1:0] use_mask;
    logic              is_copy;
    logic              is_phi;
    logic [IDX_W-1:0]  first_temp;
    logic [IDX_W-1:0]  second_temp;
  } req_word_t;

  typedef struct packed {
    logic edge_present;
    logic self_edge_error;
  } rsp_word_t;

endpackage : imb_pkg
`default_nettype wire

@@ design/interference_matrix_builder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// interference_matrix_builder
// register interference graph kept as a lower-half bit matrix in one memory
// ----------------------------------------------------------------------------
// The block keeps an interference graph over NUM_TEMPS temporaries: row r of
// a one-read one-write memory holds bit c for every edge (r, c) with c < r.
// A block-start word loads the live set, operation words (fed in reverse
// program order) add edges from their defs to every live temporary, and
// add/query words touch one pair. Every request returns exactly one response
// word. An operation with member defs sweeps the matrix, reading and writing
// back every row once through the single memory port pair, one row per cycle,
// with each row's write-back in the cycle after its read; an operation with no
// member defs skips the sweep. A new request is taken once the previous one
// has handed its response to the output register, so a waiting response does
// not block the input. The matrix is empty after reset with no clearing pass:
// a valid flop per row makes a row never written read as zero. Configuration
// writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module interference_matrix_builder
  import imb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // request channel
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire req_word_t            req,
  // response channel
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output rsp_word_t                 rsp,
  // configuration write port
  input  wire logic                 cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RMW   = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  localparam logic [TEMP_W-1:0] LAST_ROW = TEMP_W'(NUM_TEMPS - 1);

  state_t state;

  // configuration
  logic [NUM_TEMPS-1:0] member_mask;
  logic                 coalesce_en;

  // live set and sweep operands
  logic [NUM_TEMPS-1:0] live_set;
  logic [NUM_TEMPS-1:0] sw_live;
  logic [NUM_TEMPS-1:0] sw_defs;
  logic [TEMP_W-1:0]    cnt;

  // single pair request context
  logic                 op_add;
  logic                 op_ok;
  logic [TEMP_W-1:0]    op_lo;
  logic [TEMP_W-1:0]    op_hi;
  rsp_word_t            res;

  // matrix memory and its row valid flops
  logic [NUM_TEMPS-1:0] row_mem [NUM_TEMPS];
  logic [NUM_TEMPS-1:0] row_valid;
  logic [NUM_TEMPS-1:0] rd_data;
  logic                 rd_vld;
  logic [NUM_TEMPS-1:0] eff_row;

  // trailing write stage of the sweep
  logic                 wr_pend;
  logic [TEMP_W-1:0]    wr_addr;
  logic [NUM_TEMPS-1:0] wr_mask;

  logic                 mem_we;
  logic [TEMP_W-1:0]    mem_waddr;
  logic [NUM_TEMPS-1:0] mem_wdata;
  logic [TEMP_W-1:0]    mem_raddr;

  logic                 req_acc;
  logic                 rsp_load;

  // request decode
  logic [IDX_W-1:0]     in_hi;
  logic [IDX_W-1:0]     in_lo;
  logic                 in_same;
  logic                 in_range;
  logic [NUM_TEMPS-1:0] in_defs;
  logic [NUM_TEMPS-1:0] in_uses;
  logic [NUM_TEMPS-1:0] live_cut;
  logic [NUM_TEMPS-1:0] live_op;
  logic [NUM_TEMPS-1:0] low_mask;
  logic [NUM_TEMPS-1:0] sweep_mask;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  // response register frees up when empty or being taken
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    in_hi    = (req.first_temp > req.second_temp) ? req.first_temp : req.second_temp;
    in_lo    = (req.first_temp > req.second_temp) ? req.second_temp : req.first_temp;
    in_same  = (req.first_temp == req.second_temp);
    in_range = ({1'b0, in_hi} < (IDX_W + 1)'(NUM_TEMPS));
    in_defs  = req.def_mask[NUM_TEMPS-1:0] & member_mask;
    in_uses  = req.use_mask[NUM_TEMPS-1:0] & member_mask;
    // coalescing drops copy sources before the defs go live
    live_cut = (req.is_copy && coalesce_en) ? (live_set & ~in_uses) : live_set;
    live_op  = live_cut | in_defs;
  end

  // new bits of row cnt: a def row takes all lower live columns, a live row
  // takes all lower def columns
  always_comb begin
    low_mask   = (NUM_TEMPS'(1) << cnt) - NUM_TEMPS'(1);
    sweep_mask = ((sw_defs[cnt] ? sw_live : '0) | (sw_live[cnt] ? sw_defs : '0))
                 & low_mask;
  end

  // a row never written reads as zero
  assign eff_row = rd_vld ? rd_data : '0;

  // memory port muxing
  always_comb begin
    mem_raddr = (state == S_SWEEP) ? cnt : in_hi[TEMP_W-1:0];
    if (wr_pend) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr;
      mem_wdata = eff_row | wr_mask;
    end else begin
      mem_we    = (state == S_RMW) && op_add && op_ok;
      mem_waddr = op_hi;
      mem_wdata = eff_row | (NUM_TEMPS'(1) << op_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= row_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (mem_we) begin
        row_valid[mem_waddr] <= 1'b1;
      end
      rd_vld <= row_valid[mem_raddr];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      member_mask <= '1;
      coalesce_en <= 1'b1;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_MEMBER_MASK: member_mask <= cfg_data[NUM_TEMPS-1:0];
        CFG_COALESCE_EN: coalesce_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      live_set <= '0;
      wr_pend  <= 1'b0;
      cnt      <= '0;
    end else begin
      wr_pend <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            unique case (req.req_type)
              REQ_BLOCK_START: begin
                res      <= '0;
                live_set <= req.live_init_mask[NUM_TEMPS-1:0] & member_mask;
                state    <= S_DONE;
              end
              REQ_OPERATION: begin
                res      <= '0;
                sw_live  <= live_op;
                sw_defs  <= in_defs;
                cnt      <= '0;
                // phi defs stay live and its uses are not added
                live_set <= req.is_phi ? live_op : ((live_op & ~in_defs) | in_uses);
                state    <= (in_defs != '0) ? S_SWEEP : S_DONE;
              end
              REQ_ADD_EDGE, REQ_QUERY_EDGE: begin
                op_add <= (req.req_type == REQ_ADD_EDGE);
                op_ok  <= !in_same && in_range;
                op_hi  <= in_hi[TEMP_W-1:0];
                op_lo  <= in_lo[TEMP_W-1:0];
                res    <= '{edge_present: 1'b0,
                            self_edge_error: (req.req_type == REQ_ADD_EDGE) && in_same};
                state  <= S_RMW;
              end
              default: begin
                res   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RMW: begin
          if (!op_add) begin
            res.edge_present <= op_ok && eff_row[op_lo];
          end
          state <= S_DONE;
        end
        S_SWEEP: begin
          // read row cnt now, write it back with its new bits next cycle
          wr_pend <= 1'b1;
          wr_addr <= cnt;
          wr_mask <= sweep_mask;
          cnt     <= cnt + 1'b1;
          if (cnt == LAST_ROW) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= res;
    end
  end

  // checks
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && (state == S_IDLE)))
    else $error("matrix write while idle");

  a_acc_busy: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> (state != S_IDLE))
    else $error("request accepted without leaving idle");

  a_sweep_wb: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |=> wr_pend)
    else $error("sweep row read without write-back");

  a_rsp_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.edge_present && rsp.self_edge_error))
    else $error("response flags both set");

endmodule : interference_matrix_builder
`default_nettype wire
